// ===== hdl/ufia_pkg.sv =====
// Shared types and constants for the user and flow id assigner.
// No dependencies; imported by user_flow_id_assigner.
`timescale 1ns / 1ps

package ufia_pkg;

  // Key and port-side widths
  localparam int KEY_W     = 48;
  localparam int IN_DATA_W = 96;
  localparam int OUT_DATA_W = 8;
  localparam int USER_ID_W = 4;
  localparam int FLOW_ID_W = 3;
  localparam int STATUS_W  = 2;

  typedef logic [KEY_W-1:0] key_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_USER_FULL = 2'd1,
    ST_FLOW_FULL = 2'd2
  } status_t;

endpackage

// ===== hdl/user_flow_id_assigner.sv =====
// User and flow id assigner: top level with the scan sequencer and key memories.
// Depends on ufia_pkg.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel s_*: one packet header per word. s_tuser carries the
//   first-of-batch flag, which empties the user and flow tables before the
//   header is handled. Output channel m_*: one result word per header, the
//   user id and flow number in m_tdata and the status code in m_tuser
//   (0 ok, 1 user table full, 2 flow table of that user full).
//   One header is in flight at a time: s_tready is high only while the block
//   is idle. After acceptance the block scans the known users and compares the
//   last one read, fetches the flow count of the matching user, then scans that
//   user's flows and compares the last one read. A new user ends after the user
//   scan. The next header is taken only once the result has been accepted and
//   the block is idle again. The scan time is set by the single read port of
//   each key memory, scanned one entry a cycle through one 48-bit compare.
//   If the receiver stalls, the result holds on m_tdata/m_tuser and no new
//   header is taken until it is accepted.
//   Reset empties the tables (user count to zero) and leaves the block idle;
//   the key memories are not cleared and need no clearing pass.
//
module user_flow_id_assigner #(
  parameter int MAX_USERS          = 16,
  parameter int MAX_FLOWS_PER_USER = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  // s_tdata: dst_address[31:0], src_port[47:32], src_address[79:48], dst_port[95:80]
  input  logic [ufia_pkg::IN_DATA_W-1:0]     s_tdata,
  // s_tuser: first_of_batch[0]
  input  logic [0:0]                         s_tuser,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // m_tdata: user_id[3:0], flow_id[6:4], zero[7]
  output logic [ufia_pkg::OUT_DATA_W-1:0]    m_tdata,
  // m_tuser: status[1:0]
  output logic [ufia_pkg::STATUS_W-1:0]      m_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready
);

  import ufia_pkg::*;

  localparam int UCW = $clog2(MAX_USERS + 1);
  localparam int UAW = (MAX_USERS > 1) ? $clog2(MAX_USERS) : 1;
  localparam int FCW = $clog2(MAX_FLOWS_PER_USER + 1);
  localparam int FAW = (MAX_USERS * MAX_FLOWS_PER_USER > 1) ?
                       $clog2(MAX_USERS * MAX_FLOWS_PER_USER) : 1;
  localparam int FLOW_DEPTH = MAX_USERS * MAX_FLOWS_PER_USER;

  typedef enum logic [2:0] {
    S_IDLE,
    S_USCAN,
    S_FCNT,
    S_FSCAN,
    S_OUT
  } state_t;

  state_t          state;
  key_t            ukey;
  key_t            fkey;
  logic [UCW-1:0]  user_count;
  logic [UCW-1:0]  uidx;
  logic [UAW-1:0]  ucmp_idx;
  logic            ucmp_vld;
  logic [UAW-1:0]  cur_u;
  logic [FCW-1:0]  fidx;
  logic [FCW-1:0]  fcmp_idx;
  logic            fcmp_vld;
  logic [USER_ID_W-1:0] user_id;
  logic [FLOW_ID_W-1:0] flow_id;
  status_t         status;

  // Memories and their registered read data
  key_t            user_mem [MAX_USERS];
  key_t            flow_mem [FLOW_DEPTH];
  logic [FCW-1:0]  fcnt_mem [MAX_USERS];
  key_t            ukey_rd;
  key_t            fkey_rd;
  logic [FCW-1:0]  fcnt_rd;

  // Scan decisions
  logic            u_hit;
  logic            u_issue;
  logic            u_full;
  logic            f_hit;
  logic            f_issue;
  logic            f_full;

  // Shared address unit: row base of a user in the flow memory
  logic [UAW-1:0]  base_u;
  logic [FAW-1:0]  flow_base;
  logic [UAW-1:0]  u_raddr;
  logic [FAW-1:0]  f_raddr;

  // Write ports
  logic            u_we;
  logic            f_we;
  logic [FAW-1:0]  f_waddr;
  logic            c_we;
  logic [UAW-1:0]  c_waddr;
  logic [FCW-1:0]  c_wdata;

  assign base_u    = (state == S_USCAN) ? user_count[UAW-1:0] : cur_u;
  assign flow_base = FAW'(FAW'(base_u) * FAW'(MAX_FLOWS_PER_USER));
  assign u_raddr   = uidx[UAW-1:0];
  assign f_raddr   = flow_base + FAW'(fidx);

  // Compare the word read last cycle and decide whether to read further
  always_comb begin
    u_hit   = ucmp_vld && (ukey_rd == ukey);
    u_issue = (uidx < user_count);
    u_full  = (user_count == UCW'(MAX_USERS));
    f_hit   = fcmp_vld && (fkey_rd == fkey);
    f_issue = (fidx < fcnt_rd);
    f_full  = (fcnt_rd == FCW'(MAX_FLOWS_PER_USER));
  end

  // Table updates for a new user or a new flow
  always_comb begin
    u_we    = 1'b0;
    f_we    = 1'b0;
    f_waddr = flow_base;
    c_we    = 1'b0;
    c_waddr = base_u;
    c_wdata = FCW'(1);
    case (state)
      S_USCAN: begin
        if (!u_hit && !u_issue && !u_full) begin
          u_we = 1'b1;
          f_we = 1'b1;
          c_we = 1'b1;
        end
      end
      S_FSCAN: begin
        if (!f_hit && !f_issue && !f_full) begin
          f_we    = 1'b1;
          f_waddr = flow_base + FAW'(fcnt_rd);
          c_we    = 1'b1;
          c_wdata = fcnt_rd + FCW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Key and count memories
  always_ff @(posedge clk) begin
    if (u_we) begin
      user_mem[user_count[UAW-1:0]] <= ukey;
    end
    ukey_rd <= user_mem[u_raddr];
  end

  always_ff @(posedge clk) begin
    if (f_we) begin
      flow_mem[f_waddr] <= fkey;
    end
    fkey_rd <= flow_mem[f_raddr];
  end

  always_ff @(posedge clk) begin
    if (c_we) begin
      fcnt_mem[c_waddr] <= c_wdata;
    end
    fcnt_rd <= fcnt_mem[cur_u];
  end

  // Sequencer: state, counters and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      user_count <= '0;
      ucmp_vld   <= 1'b0;
      fcmp_vld   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            ukey     <= s_tdata[47:0];
            fkey     <= s_tdata[95:48];
            uidx     <= '0;
            ucmp_vld <= 1'b0;
            if (s_tuser[0]) begin
              user_count <= '0;
            end
            state <= S_USCAN;
          end
        end
        S_USCAN: begin
          if (u_hit) begin
            cur_u    <= ucmp_idx;
            ucmp_vld <= 1'b0;
            state    <= S_FCNT;
          end else if (u_issue) begin
            ucmp_idx <= uidx[UAW-1:0];
            ucmp_vld <= 1'b1;
            uidx     <= uidx + UCW'(1);
          end else begin
            // New user key: register it or report a full table
            ucmp_vld <= 1'b0;
            if (u_full) begin
              user_id <= '0;
              flow_id <= '0;
              status  <= ST_USER_FULL;
            end else begin
              user_id    <= USER_ID_W'(user_count);
              flow_id    <= '0;
              status     <= ST_OK;
              user_count <= user_count + UCW'(1);
            end
            state <= S_OUT;
          end
        end
        S_FCNT: begin
          // Wait for this user's flow count to come out of its memory
          fidx     <= '0;
          fcmp_vld <= 1'b0;
          state    <= S_FSCAN;
        end
        S_FSCAN: begin
          if (f_hit) begin
            user_id  <= USER_ID_W'(cur_u);
            flow_id  <= FLOW_ID_W'(fcmp_idx);
            status   <= ST_OK;
            fcmp_vld <= 1'b0;
            state    <= S_OUT;
          end else if (f_issue) begin
            fcmp_idx <= fidx;
            fcmp_vld <= 1'b1;
            fidx     <= fidx + FCW'(1);
          end else begin
            // New flow key: append it or report a full flow table
            fcmp_vld <= 1'b0;
            if (f_full) begin
              user_id <= '0;
              flow_id <= '0;
              status  <= ST_FLOW_FULL;
            end else begin
              user_id <= USER_ID_W'(cur_u);
              flow_id <= FLOW_ID_W'(fcnt_rd);
              status  <= ST_OK;
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_tready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Drive the channels
  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = {1'b0, flow_id, user_id};
  assign m_tuser  = status;

endmodule
